// ===== src/gsa_pkg.sv =====
// ----------------------------------------------------------------------------
// gsa_pkg: shared definitions for the generational slot allocator
// Widths, item codes, handle states and the controller/datapath interface
// structs.
// ----------------------------------------------------------------------------
package gsa_pkg;

	localparam int SLOTS    = 1024;
	localparam int GEN_BITS = 16;
	localparam int IDX_W    = $clog2(SLOTS);
	localparam int CNT_W    = $clog2(SLOTS + 1);

	typedef logic [1:0]          mode_t;
	typedef logic [1:0]          hstate_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [GEN_BITS-1:0] gen_t;

	localparam mode_t MODE_ALLOC   = 2'd0;
	localparam mode_t MODE_SET     = 2'd1;
	localparam mode_t MODE_CHECK   = 2'd2;
	localparam mode_t MODE_REBUILD = 2'd3;

	localparam hstate_t HS_NULL    = 2'd0;
	localparam hstate_t HS_INVALID = 2'd1;
	localparam hstate_t HS_ACTIVE  = 2'd2;
	localparam hstate_t HS_STALE   = 2'd3;

	// Read address sources for the slot tables.
	localparam logic RD_HANDLE = 1'b0;
	localparam logic RD_STACK  = 1'b1;

	typedef struct packed {
		logic latch;      // capture the accepted item
		logic stk_rd;     // read the top of the free stack
		logic mem_rd;     // read generation and alive flag
		logic rd_sel;     // RD_HANDLE or RD_STACK
		logic scan_start; // begin the rebuild sweep
		logic scan_run;   // advance the rebuild sweep
		logic finish;     // commit the item and load the result
	} gsa_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  top_nz;    // free stack is not empty
		logic  check_rd;  // check item needs a table lookup
		logic  scan_done;
		logic  out_free;  // result register can take a result
	} gsa_stat_t;

endpackage

// ===== src/gsa_if.sv =====
// ----------------------------------------------------------------------------
// gsa_if: request and response channels of the slot allocator
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface gsa_req_if;
	import gsa_pkg::*;

	logic  valid;
	logic  ready;
	mode_t mode;
	logic  handle_null;
	idx_t  handle_index;
	gen_t  handle_generation;
	logic  alive_value;

	modport source (output valid, mode, handle_null, handle_index, handle_generation,
		alive_value, input ready);
	modport sink (input valid, mode, handle_null, handle_index, handle_generation,
		alive_value, output ready);
endinterface

interface gsa_rsp_if;
	import gsa_pkg::*;

	logic    valid;
	logic    ready;
	idx_t    out_index;
	gen_t    out_generation;
	logic    alloc_ok;
	hstate_t handle_class;
	logic    drop_handle;
	cnt_t    free_count;

	modport source (output valid, out_index, out_generation, alloc_ok, handle_class,
		drop_handle, free_count, input ready);
	modport sink (input valid, out_index, out_generation, alloc_ok, handle_class,
		drop_handle, free_count, output ready);
endinterface

// ===== src/generational_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// generational_slot_allocator: slot table with generation-checked handles
// Top level joining the sequencing state machine and the table datapath.
// ----------------------------------------------------------------------------
// Each request transaction yields exactly one response transaction, and one
// request is in work at a time, while the previous response may still wait
// in the output register. Set-alive, append-allocate, full-table and null or
// out-of-range checks load the response straight from dispatch, a table check
// first reads the generation and alive tables, and allocation from the free
// stack steps through a stack read, then a generation read, then write-back,
// all paced by the single read port of each table. The next request is
// accepted from the cycle after the response is loaded, and loading waits for
// as long as the previous response is still held in the output register and
// not taken. The end-of-tick rebuild sweeps the alive table one slot per
// cycle. No clearing pass runs after reset: slots are only read once they
// have been appended.
module generational_slot_allocator (
	input logic       clk,
	input logic       arst_n,
	gsa_req_if.sink   req,
	gsa_rsp_if.source rsp
);
	import gsa_pkg::*;

	gsa_cmd_t  cmd;
	gsa_stat_t st;

	gsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.st       (st),
		.cmd      (cmd)
	);

	gsa_dp u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_mode              (req.mode),
		.in_handle_null       (req.handle_null),
		.in_handle_index      (req.handle_index),
		.in_handle_generation (req.handle_generation),
		.in_alive_value       (req.alive_value),
		.cmd                  (cmd),
		.st                   (st),
		.rsp                  (rsp)
	);

endmodule

// ===== src/gsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsa_ctrl: sequencing state machine of the slot allocator
// Accepts one item at a time and steps the datapath through its table accesses.
// ----------------------------------------------------------------------------
module gsa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  gsa_pkg::gsa_stat_t st,
	output gsa_pkg::gsa_cmd_t  cmd
);
	import gsa_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DISPATCH = 3'd1;
	localparam logic [2:0] S_POP_GEN  = 3'd2;
	localparam logic [2:0] S_POP_FIN  = 3'd3;
	localparam logic [2:0] S_CHECK    = 3'd4;
	localparam logic [2:0] S_SCAN     = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q) inside
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (st.mode == MODE_ALLOC && st.top_nz) begin
					cmd.stk_rd = 1'b1;
					state_d    = S_POP_GEN;
				end else if (st.check_rd) begin
					cmd.mem_rd = 1'b1;
					cmd.rd_sel = RD_HANDLE;
					state_d    = S_CHECK;
				end else if (st.mode == MODE_REBUILD) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_POP_GEN: begin
				cmd.mem_rd = 1'b1;
				cmd.rd_sel = RD_STACK;
				state_d    = S_POP_FIN;
			end
			S_POP_FIN, S_CHECK: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (st.scan_done && st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/gsa_dp.sv =====
// ----------------------------------------------------------------------------
// gsa_dp: tables, free stack and result register of the slot allocator
// Holds the generation and alive tables, the free stack, the fill and stack
// counters, the rebuild sweep and the output register.
// ----------------------------------------------------------------------------
module gsa_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  gsa_pkg::mode_t     in_mode,
	input  logic               in_handle_null,
	input  gsa_pkg::idx_t      in_handle_index,
	input  gsa_pkg::gen_t      in_handle_generation,
	input  logic               in_alive_value,
	input  gsa_pkg::gsa_cmd_t  cmd,
	output gsa_pkg::gsa_stat_t st,
	gsa_rsp_if.source          rsp
);
	import gsa_pkg::*;

	// Tables. Only slots below the fill count are ever read, and each is
	// written when it is appended, so no clearing is needed.
	gen_t gen_mem   [SLOTS];
	logic alive_mem [SLOTS];
	idx_t stack_mem [SLOTS];

	mode_t mode_q;
	logic  hnull_q;
	idx_t  hidx_q;
	gen_t  hgen_q;
	logic  aval_q;

	cnt_t  top_q;
	cnt_t  used_q;
	idx_t  stk_q;
	gen_t  gen_rd_q;
	logic  alive_rd_q;

	cnt_t  scan_i_q;
	logic  scan_v_s1;
	idx_t  scan_idx_s1;

	logic    out_valid_q;
	idx_t    out_index_q;
	gen_t    out_gen_q;
	logic    out_ok_q;
	hstate_t out_hs_q;
	logic    out_drop_q;
	cnt_t    out_free_q;

	logic  idx_in_range;
	logic  scan_more;
	logic  rd_en;
	idx_t  rd_addr;
	cnt_t  top_m1;
	gen_t  gen_inc;
	logic  scan_push;

	logic  gen_we;
	idx_t  gen_wa;
	gen_t  gen_wd;
	logic  alive_we;
	idx_t  alive_wa;

	idx_t    res_index;
	gen_t    res_gen;
	logic    res_ok;
	hstate_t res_hs;
	logic    res_drop;
	cnt_t    res_free;
	cnt_t    top_d;
	cnt_t    used_d;

	assign idx_in_range = ({1'b0, hidx_q} < used_q);
	assign scan_more    = (scan_i_q < used_q);
	assign top_m1       = top_q - cnt_t'(1);
	assign gen_inc      = gen_rd_q + gen_t'(1);
	assign scan_push    = cmd.scan_run && scan_v_s1 && !alive_rd_q;

	assign rd_en   = cmd.mem_rd || (cmd.scan_run && scan_more);
	assign rd_addr = cmd.scan_run ? scan_i_q[IDX_W-1:0] :
		(cmd.rd_sel == RD_STACK) ? stk_q : hidx_q;

	assign st.mode      = mode_q;
	assign st.top_nz    = (top_q != '0);
	assign st.check_rd  = (mode_q == MODE_CHECK) && !hnull_q && idx_in_range;
	assign st.scan_done = !scan_more && !scan_v_s1;
	assign st.out_free  = !out_valid_q || rsp.ready;

	// Commit of an item and the result it yields.
	always_comb begin
		gen_we    = 1'b0;
		gen_wa    = stk_q;
		gen_wd    = gen_inc;
		alive_we  = 1'b0;
		alive_wa  = stk_q;
		res_index = '0;
		res_gen   = '0;
		res_ok    = 1'b0;
		res_hs    = HS_NULL;
		res_drop  = 1'b0;
		top_d     = top_q;
		used_d    = used_q;
		unique case (mode_q)
			MODE_ALLOC: begin
				if (top_q != '0) begin
					gen_we    = cmd.finish;
					alive_we  = cmd.finish;
					top_d     = top_m1;
					res_index = stk_q;
					res_gen   = gen_inc;
					res_ok    = 1'b1;
				end else if (used_q < cnt_t'(SLOTS)) begin
					gen_we    = cmd.finish;
					gen_wa    = used_q[IDX_W-1:0];
					gen_wd    = '0;
					alive_we  = cmd.finish;
					alive_wa  = used_q[IDX_W-1:0];
					used_d    = used_q + cnt_t'(1);
					res_index = used_q[IDX_W-1:0];
					res_ok    = 1'b1;
				end
			end
			MODE_SET: begin
				alive_we = cmd.finish && idx_in_range;
				alive_wa = hidx_q;
			end
			MODE_CHECK: begin
				if (hnull_q) begin
					res_hs = HS_NULL;
				end else if (!idx_in_range) begin
					res_hs = HS_INVALID;
				end else if (gen_rd_q == hgen_q) begin
					res_hs   = HS_ACTIVE;
					res_drop = !alive_rd_q;
				end else if (gen_rd_q > hgen_q) begin
					res_hs   = HS_STALE;
					res_drop = 1'b1;
				end else begin
					res_hs = HS_INVALID;
				end
			end
			MODE_REBUILD: begin
			end
			default: begin
			end
		endcase
		res_free = top_d;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q  <= in_mode;
			hnull_q <= in_handle_null;
			hidx_q  <= in_handle_index;
			hgen_q  <= in_handle_generation;
			aval_q  <= in_alive_value;
		end
		if (cmd.stk_rd) begin
			stk_q <= stack_mem[top_m1[IDX_W-1:0]];
		end
		if (rd_en) begin
			gen_rd_q   <= gen_mem[rd_addr];
			alive_rd_q <= alive_mem[rd_addr];
		end
		if (gen_we) begin
			gen_mem[gen_wa] <= gen_wd;
		end
		if (alive_we) begin
			alive_mem[alive_wa] <= aval_q;
		end
		if (scan_push) begin
			stack_mem[top_q[IDX_W-1:0]] <= scan_idx_s1;
		end
		if (cmd.scan_run) begin
			scan_idx_s1 <= scan_i_q[IDX_W-1:0];
		end
		if (cmd.finish) begin
			out_index_q <= res_index;
			out_gen_q   <= res_gen;
			out_ok_q    <= res_ok;
			out_hs_q    <= res_hs;
			out_drop_q  <= res_drop;
			out_free_q  <= res_free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q       <= '0;
			used_q      <= '0;
			scan_i_q    <= '0;
			scan_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				top_q     <= '0;
				scan_i_q  <= '0;
				scan_v_s1 <= 1'b0;
			end else if (cmd.scan_run) begin
				scan_v_s1 <= scan_more;
				if (scan_more) begin
					scan_i_q <= scan_i_q + cnt_t'(1);
				end
				if (scan_push) begin
					top_q <= top_q + cnt_t'(1);
				end
			end
			if (cmd.finish) begin
				top_q  <= top_d;
				used_q <= used_d;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.out_index      = out_index_q;
	assign rsp.out_generation = out_gen_q;
	assign rsp.alloc_ok       = out_ok_q;
	assign rsp.handle_class   = out_hs_q;
	assign rsp.drop_handle    = out_drop_q;
	assign rsp.free_count     = out_free_q;

endmodule

// ===== dv/gsa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsa_checker: response checker for the generational slot allocator
// Watches both channels, keeps its own copy of the slot table, predicts the
// response of every accepted request and compares it field by field with
// the responses in order. Reports the error count and the number of
// responses still owed to the testbench top.
// ----------------------------------------------------------------------------
module gsa_checker (
	input  logic clk,
	input  logic arst_n,
	gsa_req_if   req,
	gsa_rsp_if   rsp,
	output int   errors,
	output int   pending,
	output int   compared
);
	import gsa_pkg::*;

	typedef struct packed {
		idx_t    index;
		gen_t    generation;
		logic    ok;
		hstate_t state;
		logic    drop;
		cnt_t    free_cnt;
	} slot_result_t;

	gen_t slot_gen   [SLOTS];
	logic slot_alive [SLOTS];
	idx_t free_slots [SLOTS];
	cnt_t stack_top;
	cnt_t used;

	slot_result_t owed_responses[$];

	// Applies one request to the shadow table and returns the response it causes.
	task automatic step_slot_table(input mode_t mode, input logic hnull, input idx_t hidx,
		input gen_t hgen, input logic aval, output slot_result_t res);
		idx_t slot;
		logic granted;
		res     = '0;
		granted = 1'b0;
		slot    = '0;
		case (mode)
			MODE_ALLOC: begin
				if (stack_top != 0) begin
					stack_top      = stack_top - 1'b1;
					slot           = free_slots[stack_top[IDX_W-1:0]];
					slot_gen[slot] = slot_gen[slot] + 1'b1;
					granted        = 1'b1;
				end else if (used < SLOTS) begin
					slot           = used[IDX_W-1:0];
					used           = used + 1'b1;
					slot_gen[slot] = '0;
					granted        = 1'b1;
				end
				if (granted) begin
					slot_alive[slot] = aval;
					res.index        = slot;
					res.generation   = slot_gen[slot];
					res.ok           = 1'b1;
				end
			end
			MODE_SET: begin
				if (hidx < used)
					slot_alive[hidx] = aval;
			end
			MODE_CHECK: begin
				if (hnull) begin
					res.state = HS_NULL;
				end else if (hidx >= used) begin
					res.state = HS_INVALID;
				end else if (slot_gen[hidx] == hgen) begin
					res.state = HS_ACTIVE;
					res.drop  = !slot_alive[hidx];
				end else if (slot_gen[hidx] > hgen) begin
					res.state = HS_STALE;
					res.drop  = 1'b1;
				end else begin
					res.state = HS_INVALID;
				end
			end
			default: begin
				// The rebuild leaves the highest dead slot on top of the stack.
				stack_top = '0;
				for (int i = 0; i < SLOTS; i++) begin
					if (i < used && !slot_alive[idx_t'(i)]) begin
						free_slots[stack_top[IDX_W-1:0]] = idx_t'(i);
						stack_top                        = stack_top + 1'b1;
					end
				end
			end
		endcase
		res.free_cnt = stack_top;
	endtask

	function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		slot_result_t want;
		int bad;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_gen[idx_t'(i)]   = '0;
				slot_alive[idx_t'(i)] = 1'b0;
				free_slots[idx_t'(i)] = '0;
			end
			stack_top = '0;
			used      = '0;
			owed_responses.delete();
			errors   <= 0;
			pending  <= 0;
			compared <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (owed_responses.size() == 0) begin
					$display("%0t ns: response transaction with no request outstanding", $time);
					errors <= errors + 1;
				end else begin
					want = owed_responses.pop_front();
					bad  = 0;
					bad += field_differs("out_index", want.index, rsp.out_index);
					bad += field_differs("out_generation", want.generation, rsp.out_generation);
					bad += field_differs("alloc_ok", want.ok, rsp.alloc_ok);
					bad += field_differs("handle_class", want.state, rsp.handle_class);
					bad += field_differs("drop_handle", want.drop, rsp.drop_handle);
					bad += field_differs("free_count", want.free_cnt, rsp.free_count);
					if (bad != 0)
						errors <= errors + 1;
					compared <= compared + 1;
				end
			end
			if (req.valid && req.ready) begin
				step_slot_table(req.mode, req.handle_null, req.handle_index,
					req.handle_generation, req.alive_value, want);
				owed_responses.push_back(want);
			end
			pending <= owed_responses.size();
		end
	end

endmodule

// ===== dv/tb_generational_slot_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_generational_slot_allocator: testbench top for the slot allocator
// Drives request transactions in bursts with gaps, stalls the response
// channel on its own pattern, holds it off once for a long stretch and
// leaves the checking to gsa_checker. Prints the verdict at the end of the run.
// ----------------------------------------------------------------------------
module tb_generational_slot_allocator;
	import gsa_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 300;
	localparam int PRESS_ITEMS  = 40;
	localparam int WIDE_ITEMS   = 40;
	localparam int LONG_HOLD    = 300;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic  req_valid = 1'b0;
	mode_t req_mode  = MODE_ALLOC;
	logic  req_null  = 1'b0;
	idx_t  req_index = '0;
	gen_t  req_gen   = '0;
	logic  req_alive = 1'b0;
	logic  rsp_ready = 1'b0;

	gsa_req_if req_bus ();
	gsa_rsp_if rsp_bus ();

	assign req_bus.valid             = req_valid;
	assign req_bus.mode              = req_mode;
	assign req_bus.handle_null       = req_null;
	assign req_bus.handle_index      = req_index;
	assign req_bus.handle_generation = req_gen;
	assign req_bus.alive_value       = req_alive;
	assign rsp_bus.ready             = rsp_ready;

	int errors;
	int pending;
	int compared;
	int cycles = 0;
	int burst_left = 0;
	bit gaps_on = 1'b1;
	int sent_by_mode [4] = '{0, 0, 0, 0};

	logic hold_request = 1'b0;
	logic hold_done    = 1'b0;
	int   hold_left    = 0;
	int   segment_left = 0;
	int   ready_style  = 0;
	int   pattern_tick = 0;

	generational_slot_allocator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	gsa_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_bus),
		.rsp      (rsp_bus),
		.errors   (errors),
		.pending  (pending),
		.compared (compared)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d responses owed", cycles, pending);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Response side: segments of differing stall styles, plus one long hold-off.
	always @(posedge clk) begin
		pattern_tick <= pattern_tick + 1;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_request && !hold_done) begin
			rsp_ready <= 1'b0;
			hold_left <= LONG_HOLD;
			hold_done <= 1'b1;
		end else begin
			if (segment_left == 0) begin
				ready_style  <= $urandom_range(0, 3);
				segment_left <= $urandom_range(10, 60);
			end else begin
				segment_left <= segment_left - 1;
			end
			case (ready_style)
				0:       rsp_ready <= 1'b1;
				1:       rsp_ready <= 1'($urandom_range(0, 1));
				2:       rsp_ready <= ($urandom_range(0, 3) == 0);
				default: rsp_ready <= (pattern_tick % 3 == 0);
			endcase
		end
	end

	task automatic send_item(input mode_t m, input logic n, input idx_t i, input gen_t g,
		input logic a);
		int gap;
		if (burst_left == 0) begin
			gap = gaps_on ? $urandom_range(0, 8) : 0;
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		req_valid <= 1'b1;
		req_mode  <= m;
		req_null  <= n;
		req_index <= i;
		req_gen   <= g;
		req_alive <= a;
		do @(posedge clk); while (!req_bus.ready);
		sent_by_mode[m]++;
	endtask

	// Holds the sender off until every response has come back.
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		burst_left = 0;
	endtask

	// Mostly handles near the live part of the table with small generations,
	// so that active and stale handles come up often.
	task automatic random_item(input int idx_span);
		int    r;
		mode_t m;
		logic  n;
		idx_t  i;
		gen_t  g;
		logic  a;
		r = $urandom_range(0, 99);
		if (r < 34)
			m = MODE_ALLOC;
		else if (r < 58)
			m = MODE_SET;
		else if (r < 94)
			m = MODE_CHECK;
		else
			m = MODE_REBUILD;
		if ($urandom_range(0, 3) != 0)
			i = idx_t'($urandom_range(0, idx_span));
		else
			i = idx_t'($urandom());
		case ($urandom_range(0, 9))
			0, 1:    g = gen_t'($urandom());
			2:       g = gen_t'(32'hFFFF - $urandom_range(0, 2));
			default: g = gen_t'($urandom_range(0, 3));
		endcase
		n = (m == MODE_CHECK) ? ($urandom_range(0, 9) == 0) : 1'($urandom_range(0, 1));
		a = ($urandom_range(0, 4) < 3);
		send_item(m, n, i, g, a);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: null, out-of-range check and set, rebuild of nothing.
		send_item(MODE_CHECK, 1'b1, 10'd1023, 16'hFFFF, 1'b1);
		send_item(MODE_CHECK, 1'b0, 10'd0, 16'd0, 1'b0);
		send_item(MODE_SET, 1'b0, 10'd0, 16'd0, 1'b1);
		send_item(MODE_REBUILD, 1'b0, 10'd0, 16'd0, 1'b0);
		// Appends, then active and invalid handle checks against them.
		send_item(MODE_ALLOC, 1'b0, 10'd1023, 16'hFFFF, 1'b0);
		send_item(MODE_ALLOC, 1'b1, 10'd0, 16'd0, 1'b1);
		send_item(MODE_ALLOC, 1'b0, 10'd5, 16'd7, 1'b0);
		send_item(MODE_CHECK, 1'b0, 10'd0, 16'd0, 1'b0);
		send_item(MODE_CHECK, 1'b0, 10'd1, 16'd0, 1'b0);
		send_item(MODE_CHECK, 1'b0, 10'd1, 16'hFFFF, 1'b0);
		send_item(MODE_CHECK, 1'b0, 10'd1023, 16'd0, 1'b0);
		send_item(MODE_SET, 1'b0, 10'd1, 16'd0, 1'b0);
		send_item(MODE_SET, 1'b1, 10'd1023, 16'hFFFF, 1'b1);
		// Rebuild puts all three dead slots back; reuse bumps generations.
		send_item(MODE_REBUILD, 1'b1, 10'd1023, 16'hFFFF, 1'b1);
		send_item(MODE_ALLOC, 1'b0, 10'd0, 16'd0, 1'b1);
		send_item(MODE_CHECK, 1'b0, 10'd2, 16'd0, 1'b0);
		send_item(MODE_CHECK, 1'b0, 10'd2, 16'd1, 1'b0);
		send_item(MODE_ALLOC, 1'b0, 10'd0, 16'd0, 1'b1);
		send_item(MODE_ALLOC, 1'b0, 10'd0, 16'd0, 1'b1);
		send_item(MODE_ALLOC, 1'b0, 10'd0, 16'd0, 1'b1);
		send_item(MODE_CHECK, 1'b1, 10'd0, 16'd1, 1'b0);
		send_item(MODE_SET, 1'b0, 10'd2, 16'd0, 1'b0);
		send_item(MODE_CHECK, 1'b0, 10'd2, 16'd1, 1'b0);
		drain();

		// Back-to-back requests against a long response hold-off.
		gaps_on = 1'b0;
		hold_request <= 1'b1;
		repeat (PRESS_ITEMS) random_item(47);
		gaps_on = 1'b1;

		repeat (RANDOM_ITEMS) random_item(47);
		drain();

		// Handles spread over the whole index range.
		repeat (WIDE_ITEMS) random_item(SLOTS - 1);

		drain();
		repeat (20) @(posedge clk);
		$display("Covered %0d allocate, %0d set-alive, %0d check and %0d rebuild transactions,",
			sent_by_mode[MODE_ALLOC], sent_by_mode[MODE_SET], sent_by_mode[MODE_CHECK],
			sent_by_mode[MODE_REBUILD]);
		$display("with bursty requests and a long response hold-off; %0d responses compared.",
			compared);
		if (errors == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
src/gsa_pkg.sv
src/gsa_if.sv
src/gsa_ctrl.sv
src/gsa_dp.sv
src/generational_slot_allocator.sv
dv/gsa_checker.sv
dv/tb_generational_slot_allocator.sv
